FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top-level RTL file of the search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/gnls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated nearest landmark search package
// Widths, codes and payload types shared by the search block's modules.
// ----------------------------------------------------------------------------
package gnls_pkg;

  localparam int MAX_LANDMARKS = 64;
  localparam int IDX_W         = $clog2(MAX_LANDMARKS);
  localparam int CNT_W         = $clog2(MAX_LANDMARKS + 1);
  localparam int GATE_W        = 23;
  localparam int POS_W         = 24;
  localparam int ID_W          = 16;
  localparam int SQ_W          = 2 * POS_W;
  localparam int DIST_W        = 50;

  localparam logic [GATE_W-1:0] GATE_RESET = 23'd12800;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_code_t;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ID_W-1:0]         mark_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   nearest_id;
    logic [DIST_W-1:0] nearest_sq_dist;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } mark_t;

  typedef struct packed {
    logic            valid;
    logic            gate_ok;
    logic [ID_W-1:0] id;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
  } dist_t;

endpackage

FILE: rtl/core/gated_nearest_landmark_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated nearest landmark search
// Landmark table with a gated nearest-neighbor query over its entries.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid / req_stall / req_data and each one produces
// exactly one response on rsp_valid / rsp_stall / rsp_data. A transfer takes
// place at a rising edge with valid high and stall low.
// A clear or an append passes through the emit state, which loads its
// response into the output register once that register is free; the block
// then returns to idle for the next request. A query scans the N stored
// landmarks one per cycle through the shared distance unit, a pipeline of
// three registers from the table read to the running minimum, and its
// response is loaded once every landmark has been issued and the pipeline has drained.
// The request side stalls while a query scans or a response is being posted.
// When the receiver stalls, the response holds in the output register; the
// next request is still taken, and its response waits for that register.
// gate_range is written through cfg_we / cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset empties the table, drops any response and sets gate_range to 12800.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gated_nearest_landmark_search_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gnls_pkg::GATE_W-1:0]   cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  gnls_pkg::req_t                req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output gnls_pkg::rsp_t                rsp_data
);

  gnls_pkg::state_t state;
  gnls_pkg::state_t state_next;

  logic [gnls_pkg::CNT_W-1:0]  count;
  logic [gnls_pkg::GATE_W-1:0] gate_range;
  logic [gnls_pkg::CNT_W-1:0]  scan_idx;

  gnls_pkg::mark_t mark_mem [gnls_pkg::MAX_LANDMARKS];
  gnls_pkg::mark_t rd_mark;
  logic            rd_valid;

  gnls_pkg::req_t qry;
  logic           pend_query;
  logic [1:0]     pend_status;

  logic                          found;
  logic [gnls_pkg::ID_W-1:0]     best_id;
  logic [gnls_pkg::DIST_W-1:0]   best_d;

  gnls_pkg::dist_t              dres;
  logic                         dist_busy;
  logic [gnls_pkg::DIST_W-1:0]  dsum;

  logic accept;
  logic is_append;
  logic is_query;
  logic table_full;
  logic issue;
  logic scan_done;
  logic emit;
  logic upd;

  gnls_dist_unit u_dist (
    .clk        (clk),
    .rst        (rst),
    .mark_valid (rd_valid),
    .mark       (rd_mark),
    .obs_x      (qry.pos_x),
    .obs_y      (qry.pos_y),
    .part_x     (qry.pose_x),
    .part_y     (qry.pose_y),
    .gate       (gate_range),
    .res        (dres),
    .busy       (dist_busy)
  );

  always_comb begin
    accept     = req_valid && !req_stall;
    is_append  = req_data.req_type == gnls_pkg::REQ_APPEND;
    is_query   = req_data.req_type == gnls_pkg::REQ_QUERY;
    table_full = count >= gnls_pkg::CNT_W'(gnls_pkg::MAX_LANDMARKS);
    scan_done  = (scan_idx >= count) && !rd_valid && !dist_busy;
    dsum       = {2'b00, dres.sq_x} + {2'b00, dres.sq_y};
    upd        = dres.valid && dres.gate_ok && (!found || (dsum < best_d));
  end

  always_comb begin
    state_next = state;
    case (state)
      gnls_pkg::S_IDLE: begin
        if (accept) begin
          state_next = is_query ? gnls_pkg::S_SCAN : gnls_pkg::S_EMIT;
        end
      end
      gnls_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = gnls_pkg::S_EMIT;
        end
      end
      gnls_pkg::S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = gnls_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gnls_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    issue     = 1'b0;
    emit      = 1'b0;
    case (state)
      gnls_pkg::S_IDLE: begin
        req_stall = 1'b0;
      end
      gnls_pkg::S_SCAN: begin
        issue = scan_idx < count;
      end
      gnls_pkg::S_EMIT: begin
        emit = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gnls_pkg::S_IDLE;
      count      <= '0;
      gate_range <= gnls_pkg::GATE_RESET;
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg_we) begin
        gate_range <= cfg_data;
      end
      if (accept) begin
        if (req_data.req_type == gnls_pkg::REQ_CLEAR) begin
          count <= '0;
        end else if (is_append && !table_full) begin
          count <= count + gnls_pkg::CNT_W'(1);
        end
      end
      if (accept) begin
        scan_idx <= '0;
      end else if (issue) begin
        scan_idx <= scan_idx + gnls_pkg::CNT_W'(1);
      end
      if (accept) begin
        found <= 1'b0;
      end else if (upd) begin
        found <= 1'b1;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_append && !table_full) begin
      mark_mem[count[gnls_pkg::IDX_W-1:0]] <= '{id: req_data.mark_id,
                                                x:  req_data.pos_x,
                                                y:  req_data.pos_y};
    end
    if (issue) begin
      rd_mark <= mark_mem[scan_idx[gnls_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qry         <= req_data;
      pend_query  <= is_query;
      pend_status <= (is_append && table_full) ? gnls_pkg::ST_FULL : gnls_pkg::ST_DONE;
    end
    if (upd) begin
      best_id <= dres.id;
      best_d  <= dsum;
    end
    if (emit) begin
      if (pend_query && found) begin
        rsp_data <= '{status: gnls_pkg::ST_DONE, nearest_id: best_id,
                      nearest_sq_dist: best_d};
      end else if (pend_query) begin
        rsp_data <= '{status: gnls_pkg::ST_NO_MATCH, nearest_id: '0,
                      nearest_sq_dist: '0};
      end else begin
        rsp_data <= '{status: pend_status, nearest_id: '0, nearest_sq_dist: '0};
      end
    end
  end

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= gnls_pkg::CNT_W'(gnls_pkg::MAX_LANDMARKS))
  `ASSERT_IMPLY(a_scan_bound, clk, rst, state == gnls_pkg::S_SCAN, scan_idx <= count)
  `ASSERT_IMPLY(a_pipe_in_scan, clk, rst, rd_valid || dist_busy, state == gnls_pkg::S_SCAN)
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != gnls_pkg::S_IDLE)
  `ASSERT_IMPLY(a_no_match_zero, clk, rst,
                rsp_valid && rsp_data.status == gnls_pkg::ST_NO_MATCH,
                rsp_data.nearest_id == '0 && rsp_data.nearest_sq_dist == '0)

endmodule

FILE: rtl/core/gnls_dist_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark distance unit
// Two-stage pipeline that gates one stored landmark against the particle and
// squares its offsets from the observation. It is reused for every landmark.
// ----------------------------------------------------------------------------
module gnls_dist_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             mark_valid,
  input  gnls_pkg::mark_t                  mark,
  input  logic signed [gnls_pkg::POS_W-1:0] obs_x,
  input  logic signed [gnls_pkg::POS_W-1:0] obs_y,
  input  logic signed [gnls_pkg::POS_W-1:0] part_x,
  input  logic signed [gnls_pkg::POS_W-1:0] part_y,
  input  logic [gnls_pkg::GATE_W-1:0]       gate,
  output gnls_pkg::dist_t                  res,
  output logic                             busy
);

  function automatic logic [gnls_pkg::POS_W-1:0] abs_diff(
    input logic signed [gnls_pkg::POS_W-1:0] a,
    input logic signed [gnls_pkg::POS_W-1:0] b
  );
    logic signed [gnls_pkg::POS_W:0] d;
    d = {a[gnls_pkg::POS_W-1], a} - {b[gnls_pkg::POS_W-1], b};
    abs_diff = d[gnls_pkg::POS_W] ? gnls_pkg::POS_W'(-d) : d[gnls_pkg::POS_W-1:0];
  endfunction

  logic [gnls_pkg::POS_W-1:0] gate_ext;
  logic [gnls_pkg::POS_W-1:0] gx;
  logic [gnls_pkg::POS_W-1:0] gy;
  logic                       gate_ok;

  logic                       s1_valid;
  logic                       s1_gate_ok;
  logic [gnls_pkg::ID_W-1:0]  s1_id;
  logic [gnls_pkg::POS_W-1:0] s1_dx;
  logic [gnls_pkg::POS_W-1:0] s1_dy;

  always_comb begin
    gate_ext = {1'b0, gate};
    gx       = abs_diff(mark.x, part_x);
    gy       = abs_diff(mark.y, part_y);
    gate_ok  = (gx <= gate_ext) && (gy <= gate_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s1_valid  <= mark_valid;
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_gate_ok  <= gate_ok;
    s1_id       <= mark.id;
    s1_dx       <= abs_diff(obs_x, mark.x);
    s1_dy       <= abs_diff(obs_y, mark.y);
    res.gate_ok <= s1_gate_ok;
    res.id      <= s1_id;
    res.sq_x    <= s1_dx * s1_dx;
    res.sq_y    <= s1_dy * s1_dy;
  end

  assign busy = s1_valid || res.valid;

endmodule

FILE: test/gated_nearest_landmark_search_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated nearest landmark search testbench
// Loads landmark tables and runs gated queries against them. A local copy of
// the table and gate predicts every response, and each response is compared
// with the oldest prediction. A short directed part covers extreme positions,
// gate edges, ties and the unused request code. Randomized table loads, some
// of them filling the table, and queries follow under several gate settings,
// with random request gaps and response stalls except in one quiet phase.
// ----------------------------------------------------------------------------
module gated_nearest_landmark_search_top_test;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 125;
  localparam logic [gnls_pkg::GATE_W-1:0] GATE_MAX = 23'd8388607;

  class landmark_scoreboard;
    gnls_pkg::rsp_t              expected_q[$];
    gnls_pkg::mark_t             marks[gnls_pkg::MAX_LANDMARKS];
    int unsigned                 mark_count;
    logic [gnls_pkg::GATE_W-1:0] gate;
    int                          errors;

    function new();
      mark_count = 0;
      gate = gnls_pkg::GATE_RESET;
      errors = 0;
    endfunction

    function void set_gate(logic [gnls_pkg::GATE_W-1:0] g);
      gate = g;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function longint unsigned span(longint a, longint b);
      return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function void note_request(gnls_pkg::req_t r);
      gnls_pkg::rsp_t res;
      longint ox, oy, px, py, lx, ly;
      longint unsigned dx, dy, d, best;
      bit found;
      res = '0;
      found = 0;
      best = 0;
      case (r.req_type)
        gnls_pkg::REQ_CLEAR: begin
          mark_count = 0;
        end
        gnls_pkg::REQ_APPEND: begin
          if (mark_count < gnls_pkg::MAX_LANDMARKS) begin
            marks[mark_count].id = r.mark_id;
            marks[mark_count].x = r.pos_x;
            marks[mark_count].y = r.pos_y;
            mark_count++;
          end else begin
            res.status = gnls_pkg::ST_FULL;
          end
        end
        gnls_pkg::REQ_QUERY: begin
          ox = r.pos_x;
          oy = r.pos_y;
          px = r.pose_x;
          py = r.pose_y;
          for (int i = 0; i < mark_count; i++) begin
            lx = marks[i].x;
            ly = marks[i].y;
            if (span(lx, px) <= gate && span(ly, py) <= gate) begin
              dx = span(ox, lx);
              dy = span(oy, ly);
              d = dx * dx + dy * dy;
              if (!found || d < best) begin
                found = 1;
                best = d;
                res.nearest_id = marks[i].id;
              end
            end
          end
          if (found) begin
            res.nearest_sq_dist = gnls_pkg::DIST_W'(best);
          end else begin
            res.status = gnls_pkg::ST_NO_MATCH;
            res.nearest_id = '0;
          end
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_response(gnls_pkg::rsp_t got);
      gnls_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: response with none expected, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.nearest_id !== want.nearest_id) begin
        $display("%0t: nearest_id expected %h got %h", $time, want.nearest_id,
                 got.nearest_id);
        errors++;
      end
      if (got.nearest_sq_dist !== want.nearest_sq_dist) begin
        $display("%0t: nearest_sq_dist expected %0d got %0d", $time,
                 want.nearest_sq_dist, got.nearest_sq_dist);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [gnls_pkg::GATE_W-1:0] cfg_data = '0;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  gnls_pkg::req_t              req_data = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  gnls_pkg::rsp_t              rsp_data;

  landmark_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  gated_nearest_landmark_search_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(rsp_data);
    end
  end

  function automatic gnls_pkg::req_t make_req(logic [1:0] code, int id, int x, int y,
                                              int px, int py);
    gnls_pkg::req_t r;
    r.req_type = code;
    r.mark_id = gnls_pkg::ID_W'(id);
    r.pos_x = gnls_pkg::POS_W'(x);
    r.pos_y = gnls_pkg::POS_W'(y);
    r.pose_x = gnls_pkg::POS_W'(px);
    r.pose_y = gnls_pkg::POS_W'(py);
    return r;
  endfunction

  function automatic int near(int c, int spread);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic send_req(input gnls_pkg::req_t r);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic write_gate(input logic [gnls_pkg::GATE_W-1:0] g);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_gate(g);
  endtask

  task automatic send_noise();
    gnls_pkg::req_t r;
    r.req_type = 2'($urandom_range(0, 3));
    r.mark_id = gnls_pkg::ID_W'($urandom);
    r.pos_x = gnls_pkg::POS_W'($urandom);
    r.pos_y = gnls_pkg::POS_W'($urandom);
    r.pose_x = gnls_pkg::POS_W'($urandom);
    r.pose_y = gnls_pkg::POS_W'($urandom);
    send_req(r);
  endtask

  // One table load followed by a few queries around the same area.
  task automatic run_episode();
    int n, q, cx, cy, spread, x, y, px, py, ox, oy, k;
    int xs[$];
    int ys[$];
    longint wide;
    cx = $urandom;
    cy = $urandom;
    wide = 2 * longint'(sb.gate) + 2;
    if (wide > 8388608) wide = 8388608;
    spread = int'(wide);
    case ($urandom_range(0, 7))
      0, 1: spread = $urandom_range(0, 8);
      2: spread = 8388608;
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) send_req(make_req(gnls_pkg::REQ_CLEAR, $urandom, $urandom,
                                                     $urandom, $urandom, $urandom));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if (xs.size() > 0 && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(0, xs.size() - 1);
        x = xs[k];
        y = ys[k];
      end else begin
        x = near(cx, spread);
        y = near(cy, spread);
      end
      xs.insert(xs.size(), x);
      ys.insert(ys.size(), y);
      if ($urandom_range(0, 11) == 0) send_noise();
      else send_req(make_req(gnls_pkg::REQ_APPEND, $urandom, x, y, $urandom, $urandom));
    end
    q = $urandom_range(1, 6);
    for (int i = 0; i < q; i++) begin
      k = $urandom_range(0, xs.size() - 1);
      if ($urandom_range(0, 2) == 0) begin
        px = xs[k];
        py = ys[k];
      end else begin
        px = near(cx, spread);
        py = near(cy, spread);
      end
      case ($urandom_range(0, 2))
        0: begin
          k = $urandom_range(0, xs.size() - 1);
          ox = xs[k];
          oy = ys[k];
        end
        1: begin
          ox = near(px, 256);
          oy = near(py, 256);
        end
        default: begin
          ox = near(cx, spread);
          oy = near(cy, spread);
        end
      endcase
      if ($urandom_range(0, 11) == 0) send_noise();
      else send_req(make_req(gnls_pkg::REQ_QUERY, $urandom, ox, oy, px, py));
    end
  endtask

  initial begin
    logic [gnls_pkg::GATE_W-1:0] gates[10];
    int phase_start;
    gates[0] = '0;
    gates[1] = GATE_MAX;
    gates[2] = 23'd1;
    gates[3] = gnls_pkg::GATE_W'($urandom_range(2, 255));
    gates[4] = gnls_pkg::GATE_RESET;
    gates[5] = gnls_pkg::GATE_W'($urandom_range(256, 65535));
    gates[6] = gnls_pkg::GATE_W'($urandom);
    gates[7] = GATE_MAX;
    gates[8] = '0;
    gates[9] = gnls_pkg::GATE_W'($urandom_range(65536, 8388606));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks with the gate left at its reset value.
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 0, 0));
    send_req(make_req(REQ_UNUSED, 16'hFFFF, -1, -1, -1, -1));
    send_req(make_req(gnls_pkg::REQ_APPEND, 16'hFFFF, -8388608, 8388607, 0, 0));
    send_req(make_req(gnls_pkg::REQ_APPEND, 0, 8388607, -8388608, 0, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 8388607, -8388608, -8388608, 8388607));
    send_req(make_req(gnls_pkg::REQ_APPEND, 16'h1234, 0, 0, 0, 0));
    send_req(make_req(gnls_pkg::REQ_APPEND, 16'h5678, 256, 0, 0, 0));
    send_req(make_req(gnls_pkg::REQ_APPEND, 16'h9ABC, -256, 0, 0, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 0, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 128, 0, 0, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 13056, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 13057, 0));
    send_req(make_req(gnls_pkg::REQ_CLEAR, 16'hFFFF, -1, -1, -1, -1));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 0, 0));

    write_gate('0);
    send_req(make_req(gnls_pkg::REQ_APPEND, 7, 5, 5, 0, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 5, 5));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 0, 0, 6, 5));

    write_gate(GATE_MAX);
    send_req(make_req(gnls_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
    send_req(make_req(gnls_pkg::REQ_APPEND, 1, -8388608, -8388608, 0, 0));
    send_req(make_req(gnls_pkg::REQ_APPEND, 2, 8388607, 8388607, 0, 0));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, 8388607, 8388607, -1, -1));
    send_req(make_req(gnls_pkg::REQ_QUERY, 0, -8388608, -8388608, 0, 0));

    for (int p = 0; p < 10; p++) begin
      write_gate(gates[p]);
      quiet = (p == 4);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_episode();
    end
    quiet = 1'b0;

    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
